/* design/hsfr_pkg.sv */
// Shared types and constants for the header-synchronized frame receiver.
package hsfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 4;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd85;

  // Byte 3 of a frame selects its length.
  localparam logic [BYTE_W-1:0] KIND_SHORT_MAX = 8'd2;
  localparam logic [BYTE_W-1:0] KIND_SHORT_ALT = 8'd8;
  localparam logic [BYTE_W-1:0] KIND_MID       = 8'd3;
  localparam logic [BYTE_W-1:0] KIND_LONG      = 8'd14;

  localparam int LEN_SHORT = 7;
  localparam int LEN_MID   = 8;
  localparam int LEN_LONG  = 9;

  // One completed frame handed from the front to the back.
  typedef struct packed {
    logic             bank;
    logic [POS_W-1:0] last;
  } desc_t;

endpackage

/* design/hsfr_frame_buf.sv */
// Two-bank frame buffer: one write port, one registered read port.
module hsfr_frame_buf
  import hsfr_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW:0]       wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [AW:0]       rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [2**(AW+1)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/hsfr_desc_fifo.sv */
// Two-entry queue of completed-frame descriptors between front and back.
module hsfr_desc_fifo
  import hsfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

/* design/hsfr_front.sv */
// Front end: header hunt, frame fill, length decode and bank handoff.
module hsfr_front
  import hsfr_pkg::*;
#(
  parameter int MAX_FRAME = 12,
  parameter int AW        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              full,
  input  logic              cfg_valid,
  input  logic [BYTE_W-1:0] cfg_data,
  output logic              wr_en,
  output logic [AW:0]       wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              desc_push,
  output desc_t             desc_data,
  input  logic [1:0]        bank_release
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [BYTE_W-1:0] header;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;
  logic [CW-1:0]     count_next;
  logic              cur;
  logic [1:0]        busy;
  logic [1:0]        busy_set;
  logic [BYTE_W-1:0] kind;
  logic [BYTE_W-1:0] kind_now;
  logic              accept;
  logic              is_header;
  logic              done;

  assign full      = busy[cur];
  assign accept    = push && !busy[cur];
  assign is_header = (rx_byte == header);
  assign count_next = fill + CW'(1);
  assign kind_now  = (fill == CW'(3)) ? rx_byte : kind;

  always_comb begin
    done = (count_next == CW'(MAX_FRAME));
    if (count_next == CW'(LEN_SHORT) &&
        (kind_now inside {[8'd0 : KIND_SHORT_MAX], KIND_SHORT_ALT})) begin
      done = 1'b1;
    end
    if (count_next == CW'(LEN_MID) && kind_now == KIND_MID) begin
      done = 1'b1;
    end
    if (count_next == CW'(LEN_LONG) && kind_now == KIND_LONG) begin
      done = 1'b1;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = {cur, fill[AW-1:0]};
    wr_data   = rx_byte;
    desc_push = 1'b0;
    desc_data = '{bank: cur, last: POS_W'(fill)};
    busy_set  = 2'b00;
    fill_next = fill;
    if (accept) begin
      if (is_header) begin
        // Restart the frame at position 0.
        wr_en     = 1'b1;
        wr_addr   = {cur, {AW{1'b0}}};
        fill_next = CW'(1);
      end else if (fill != '0) begin
        wr_en = 1'b1;
        if (done) begin
          desc_push     = 1'b1;
          busy_set[cur] = 1'b1;
          fill_next     = '0;
        end else begin
          fill_next = count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= HEADER_RESET;
      fill   <= '0;
      cur    <= 1'b0;
      busy   <= 2'b00;
    end else begin
      if (cfg_valid) begin
        header <= cfg_data;
      end
      fill <= fill_next;
      busy <= (busy & ~bank_release) | busy_set;
      if (desc_push) begin
        cur <= ~cur;
      end
    end
    if (accept && !is_header && fill == CW'(3)) begin
      kind <= rx_byte;
    end
  end

endmodule

/* design/hsfr_back.sv */
// Back end: drains completed frames from the buffer into a two-entry output queue.
module hsfr_back
  import hsfr_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_empty,
  input  desc_t             desc_head,
  output logic              desc_pop,
  output logic [AW:0]       rd_addr,
  input  logic [BYTE_W-1:0] rd_data,
  output logic [1:0]        bank_release,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              frame_end
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } out_t;

  logic             active;
  logic             bank;
  logic [POS_W-1:0] last;
  logic [POS_W-1:0] idx;
  logic             rd_valid;
  logic [POS_W-1:0] rd_pos;
  logic             rd_end;
  out_t             q [2];
  logic             q_wr;
  logic             q_rd;
  logic [1:0]       q_cnt;
  logic             pop_ok;
  logic             issue;
  logic [2:0]       credit_use;

  assign empty         = (q_cnt == 2'd0);
  assign frame_byte    = q[q_rd].data;
  assign byte_position = q[q_rd].pos;
  assign frame_end     = q[q_rd].last;

  assign pop_ok     = pop && !empty;
  assign credit_use = 3'(q_cnt) + 3'(rd_valid) - 3'(pop_ok);
  assign issue      = active && (credit_use < 3'd2);
  assign desc_pop   = !active && !desc_empty;
  assign rd_addr    = {bank, idx[AW-1:0]};

  always_comb begin
    bank_release = 2'b00;
    if (issue && idx == last) begin
      bank_release[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
      q_wr     <= 1'b0;
      q_rd     <= 1'b0;
      q_cnt    <= 2'd0;
    end else begin
      if (desc_pop) begin
        active <= 1'b1;
      end else if (issue && idx == last) begin
        active <= 1'b0;
      end
      rd_valid <= issue;
      if (rd_valid) begin
        q_wr <= ~q_wr;
      end
      if (pop_ok) begin
        q_rd <= ~q_rd;
      end
      q_cnt <= q_cnt + 2'(rd_valid) - 2'(pop_ok);
    end
    if (desc_pop) begin
      bank <= desc_head.bank;
      last <= desc_head.last;
      idx  <= '0;
    end else if (issue) begin
      idx <= idx + POS_W'(1);
    end
    if (issue) begin
      rd_pos <= idx;
      rd_end <= (idx == last);
    end
    if (rd_valid) begin
      q[q_wr] <= '{data: rd_data, pos: rd_pos, last: rd_end};
    end
  end

endmodule

/* design/header_sync_frame_receiver.sv */
// Top level of the header-synchronized serial frame receiver.
//
//   Channel  Handshake            Payload                                 Transfer when
//   input    push / full          rx_byte                                 push && !full
//   result   empty / pop          frame_byte, byte_position, frame_end    pop && !empty
//   config   cfg_valid/cfg_ready  cfg_data (header byte)                  cfg_valid && cfg_ready
//
// One received byte is taken per cycle while full is low. A completed frame of N bytes leaves
// the result side one byte per cycle unless stalled, limited by the single read port of the
// buffer; its first byte passes the descriptor queue, buffer read register and output queue.
// Reset (rst, synchronous) restores header 85 and an empty receiver; buffer
// contents are left as they are. full rises only while both buffer banks hold
// frames waiting to drain; a stalled result side holds everything upstream.
module header_sync_frame_receiver
  import hsfr_pkg::*;
#(
  parameter int MAX_FRAME = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              frame_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  // Address bits of one buffer bank.
  localparam int AW = $clog2(MAX_FRAME);

  logic              wr_en;
  logic [AW:0]       wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [AW:0]       rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              desc_push;
  desc_t             desc_data;
  logic              desc_pop;
  desc_t             desc_head;
  logic              desc_empty;
  logic [1:0]        bank_release;

  // The header register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Front: hunt for the header, fill the current bank, hand completed banks over.
  hsfr_front #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .rx_byte      (rx_byte),
    .full         (full),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .desc_push    (desc_push),
    .desc_data    (desc_data),
    .bank_release (bank_release)
  );

  // Frame buffer shared by both halves, one bank each side at a time.
  hsfr_frame_buf #(
    .AW (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Completed-frame queue decoupling the two halves.
  hsfr_desc_fifo u_desc (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_data (desc_data),
    .pop       (desc_pop),
    .head      (desc_head),
    .empty     (desc_empty)
  );

  // Back: read each frame out in order and mark its last byte.
  hsfr_back #(
    .AW (AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_empty    (desc_empty),
    .desc_head     (desc_head),
    .desc_pop      (desc_pop),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .bank_release  (bank_release),
    .empty         (empty),
    .pop           (pop),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .frame_end     (frame_end)
  );

endmodule

/* test/hsfr_frame_checker.sv */
// Frame predictor and result checker for the header-synchronized frame receiver.
`timescale 1ns / 100ps
module hsfr_frame_checker
  import hsfr_pkg::*;
#(
  parameter int MAX_FRAME = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              empty,
  input  logic              pop,
  input  logic [BYTE_W-1:0] frame_byte,
  input  logic [POS_W-1:0]  byte_position,
  input  logic              frame_end,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  output int                mismatches,
  output int                beats_waiting
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_beat_t;

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] held_bytes [16];
  int                held_count;
  frame_beat_t       beats_due [$];

  initial begin
    mismatches    = 0;
    beats_waiting = 0;
  end

  // Byte 3 picks the frame length; anything else runs to MAX_FRAME.
  function automatic bit frame_complete(input int count);
    logic [BYTE_W-1:0] kind;
    kind = held_bytes[3];
    if (count == LEN_SHORT && (kind <= KIND_SHORT_MAX || kind == KIND_SHORT_ALT)) return 1'b1;
    if (count == LEN_MID && kind == KIND_MID) return 1'b1;
    if (count == LEN_LONG && kind == KIND_LONG) return 1'b1;
    return count >= MAX_FRAME;
  endfunction

  task automatic take_rx_byte(input logic [BYTE_W-1:0] value);
    int          count;
    frame_beat_t beat;
    count = held_count;
    if (value == header_byte) begin
      held_bytes[0] = value;
      held_count    = 1;
      return;
    end
    if (count == 0) return;
    held_bytes[count % 16] = value;
    count++;
    if (!frame_complete(count)) begin
      held_count = count;
      return;
    end
    for (int k = 0; k < count; k++) begin
      beat.data = held_bytes[k % 16];
      beat.pos  = POS_W'(k);
      beat.last = (k + 1 == count);
      beats_due.push_back(beat);
    end
    held_count = 0;
  endtask

  task automatic log_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      header_byte = HEADER_RESET;
      held_count  = 0;
      beats_due.delete();
    end else begin
      // Compare first: a byte pushed at this edge cannot surface before later edges.
      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result: byte %0d pos %0d end %0b",
                                 frame_byte, byte_position, frame_end));
        end else begin
          want = beats_due.pop_front();
          if (frame_byte !== want.data || byte_position !== want.pos ||
              frame_end !== want.last) begin
            log_mismatch($sformatf(
              "result mismatch: expected byte %0d pos %0d end %0b, got byte %0d pos %0d end %0b",
              want.data, want.pos, want.last, frame_byte, byte_position, frame_end));
          end
        end
      end
      if (cfg_valid && cfg_ready) header_byte = cfg_data;
      if (push && !full) take_rx_byte(rx_byte);
    end
    beats_waiting = beats_due.size();
  end

endmodule

/* test/tb_header_sync_frame_receiver.sv */
// Testbench top: drives received bytes, header writes and result pops, and gives the verdict.
`timescale 1ns / 100ps
module tb_header_sync_frame_receiver;
  import hsfr_pkg::*;

  localparam int MAX_FRAME      = 12;
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before the run is declared hung
  localparam int LONG_HOLD      = 400;   // one long stall of the result side
  localparam int SETTLE_CYCLES  = 12;    // covers the pipeline behind a transfer

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              push      = 1'b0;
  logic [BYTE_W-1:0] rx_byte   = '0;
  logic              pop       = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [BYTE_W-1:0] cfg_data  = '0;
  logic              full;
  logic              empty;
  logic              cfg_ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_position;
  logic              frame_end;

  int mismatches;
  int beats_waiting;
  int items_sent   = 0;
  int quiet_cycles = 0;

  // Header value currently programmed, tracked here to shape the stimulus.
  logic [BYTE_W-1:0] header_now = HEADER_RESET;

  bit send_steady   = 1'b0;
  bit pop_steady    = 1'b0;
  bit long_hold_req = 1'b0;

  // Directed opening: two dropped bytes with no frame open (extremes of the byte),
  // a short frame selected by byte 3 at its upper bound, then a frame that a
  // second header restarts mid-way and that byte 3 makes nine bytes long.
  logic [BYTE_W-1:0] opening_bytes [21] = '{
    8'h00, 8'hFF,
    HEADER_RESET, 8'hFF, 8'h00, KIND_SHORT_MAX, 8'd7, 8'd7, 8'd7,
    HEADER_RESET, 8'd1, 8'd2,
    HEADER_RESET, 8'd9, 8'd9, KIND_LONG, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5
  };

  always #5 clk = ~clk;

  header_sync_frame_receiver #(
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  hsfr_frame_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) frame_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .beats_waiting(beats_waiting)
  );

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one received byte after a random gap and hold it until the transfer.
  // With no gap, push stays high straight into the next byte.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    = 1'b1;
    rx_byte = value;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Any byte except the current header, so it lands in the frame as data.
  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] value;
    do value = BYTE_W'($urandom_range(0, 255)); while (value == header_now);
    return value;
  endfunction

  // Drop push and wait until every predicted result has drained, plus the
  // pipeline depth so that bytes causing no result are fully absorbed too.
  task automatic drain_results();
    push = 1'b0;
    wait (beats_waiting == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_header(input logic [BYTE_W-1:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  = 1'b0;
    header_now = value;
  endtask

  // Send one well-formed frame with a random length class. With restart set,
  // a truncated frame goes out first and the real header resynchronizes it.
  task automatic send_frame(input bit restart);
    logic [BYTE_W-1:0] kind;
    int                len;
    int                partial;
    case ($urandom_range(0, 7))
      0: kind = 8'd0;
      1: kind = 8'd1;
      2: kind = KIND_SHORT_MAX;
      3: kind = KIND_SHORT_ALT;
      4: kind = KIND_MID;
      5: kind = KIND_LONG;
      default: begin
        do kind = BYTE_W'($urandom_range(0, 255));
        while (kind <= KIND_SHORT_MAX || kind == KIND_SHORT_ALT ||
               kind == KIND_MID || kind == KIND_LONG);
      end
    endcase
    if (kind <= KIND_SHORT_MAX || kind == KIND_SHORT_ALT) len = LEN_SHORT;
    else if (kind == KIND_MID) len = LEN_MID;
    else if (kind == KIND_LONG) len = LEN_LONG;
    else len = MAX_FRAME;
    if (restart) begin
      partial = $urandom_range(1, len - 2);
      send_byte(header_now);
      repeat (partial) send_byte(payload_byte());
      items_sent += partial + 1;
    end
    send_byte(header_now);
    for (int i = 1; i < len; i++) send_byte(i == 3 ? kind : payload_byte());
    items_sent += len;
  endtask

  // Mostly well-formed frames, some restarted ones, and line noise between them.
  // Noise does not count toward the quota since the block mostly drops it.
  task automatic run_frames(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
        1: send_frame(1'b1);
        default: send_frame(1'b0);
      endcase
    end
  endtask

  // Result side: pop after a random gap, with one long hold on request so the
  // receiver fills both buffer banks and has to raise full.
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) pop_steady = !pop_steady;
      gap = pop_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    logic [BYTE_W-1:0] old_header;
    logic [BYTE_W-1:0] next_header;

    // Hold reset, then release it between edges.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening with the reset header.
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Lowest header; stall the result side while the sender keeps pushing.
    write_header(8'h00);
    long_hold_req = 1'b1;
    run_frames(70);

    // Highest header; pause the sender once until all results are out.
    write_header(8'hFF);
    run_frames(40);
    drain_results();
    run_frames(40);

    // Leave a frame open, then change the header under it. The old header byte
    // is plain data from then on and must not restart the frame.
    send_byte(header_now);
    send_byte(payload_byte());
    send_byte(payload_byte());
    old_header = header_now;
    do next_header = BYTE_W'($urandom_range(0, 255)); while (next_header == old_header);
    write_header(next_header);
    send_byte(old_header);
    repeat (9) send_byte(payload_byte());
    run_frames(70);

    // Back to the reset value for the last stretch.
    write_header(HEADER_RESET);
    run_frames(60);

    // Drain, then give any stray result time to show up before the verdict.
    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
